// File: rtl/cmrt_pkg.sv
// ---------------------------------------------------------------------------
// cmrt_pkg: shared types and constants
// Request/result words, status codes and sequencer states.
// ---------------------------------------------------------------------------
package cmrt_pkg;

  localparam int MAP_ENTRIES   = 64;
  localparam int FRAME_ENTRIES = 64;
  localparam int MAP_IDX_W     = $clog2(MAP_ENTRIES);
  localparam int REF_IDX_W     = $clog2(FRAME_ENTRIES);
  localparam int MAP_CNT_W     = $clog2(MAP_ENTRIES + 1);
  localparam int REF_CNT_W     = $clog2(FRAME_ENTRIES + 1);
  localparam logic [6:0] COUNT_MAX = 7'd127;

  typedef enum logic [3:0] {
    ST_SHARED    = 4'd0,
    ST_PLAIN     = 4'd1,
    ST_UNALIGNED = 4'd2,
    ST_LARGE     = 4'd3,
    ST_DUP       = 4'd4,
    ST_FULL      = 4'd5,
    ST_RESTORED  = 4'd6,
    ST_COPIED    = 4'd7,
    ST_NOT_COW   = 4'd8,
    ST_INVALID   = 4'd9,
    ST_NO_MEM    = 4'd10
  } status_t;

  localparam logic REQ_SHARE = 1'b0;
  localparam logic REQ_FAULT = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [15:0] first_pid;
    logic [15:0] child_pid;
    logic [63:0] virtual_address;
    logic [51:0] frame_address;
    logic        perm_writable;
    logic        perm_user;
    logic        perm_exec;
    logic        large_page;
    logic        trap_valid;
    logic [1:0]  fault_error_bits;
    logic        alloc_ok;
  } req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic        map_writable;
    logic        map_user;
    logic        map_exec;
    logic        parent_make_readonly;
    logic [51:0] copy_frame;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAP_RD,
    S_MAP_CHK,
    S_DECIDE,
    S_REF_RD,
    S_REF_CHK,
    S_APPLY,
    S_OUT
  } fsm_t;

endpackage

// File: rtl/cow_mapping_refcount_table_core.sv
// ---------------------------------------------------------------------------
// cow_mapping_refcount_table_core: copy-on-write page tracker
// Mapping table and frame reference-count table, walked one entry at a time.
// ---------------------------------------------------------------------------
// channel | dir | handshake       | word
// req     | in  | req_valid/stall | cmrt_pkg::req_t
// rsp     | out | rsp_valid/stall | cmrt_pkg::rsp_t
//
// Every share or fault, early rejects included, walks the mapping table and
// then the frame table, each entry through a read state and a check state
// on the registered read. The result is registered in S_APPLY and waits in
// its output register while rsp_stall is high; req_stall holds off a new
// request until the sequencer is back in S_IDLE, so requests do not
// overlap. Reset clears only the state and the valid bits. The next
// request is taken once the result has been delivered.
module cow_mapping_refcount_table_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  cmrt_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output cmrt_pkg::rsp_t rsp
);

  localparam int MW = cmrt_pkg::MAP_IDX_W;
  localparam int RW = cmrt_pkg::REF_IDX_W;

  // storage
  logic [cmrt_pkg::MAP_ENTRIES-1:0]   map_valid;
  logic [15:0] map_pid   [cmrt_pkg::MAP_ENTRIES];
  logic [51:0] map_vpn   [cmrt_pkg::MAP_ENTRIES];
  logic [39:0] map_frame [cmrt_pkg::MAP_ENTRIES];
  logic [2:0]  map_perms [cmrt_pkg::MAP_ENTRIES];
  logic [cmrt_pkg::FRAME_ENTRIES-1:0] ref_valid;
  logic [39:0] ref_frame [cmrt_pkg::FRAME_ENTRIES];
  logic [6:0]  ref_cnt   [cmrt_pkg::FRAME_ENTRIES];

  cmrt_pkg::fsm_t state, state_next;
  cmrt_pkg::req_t r;
  logic [51:0] page;
  logic [39:0] frame;

  logic [cmrt_pkg::MAP_CNT_W-1:0] mi;
  logic [cmrt_pkg::REF_CNT_W-1:0] ri;
  logic [15:0] rd_pid;
  logic [51:0] rd_page;
  logic        rd_valid;
  logic [39:0] rd_rframe;
  logic [6:0]  rd_rcnt;
  logic        rd_rvalid;

  // walk results
  logic          pm_hit, cm_hit, s1_ok, s2_ok, rf_hit, rf_free_ok;
  logic [MW-1:0] pm_idx, s1_idx, s2_idx;
  logic [RW-1:0] rf_idx, rf_free;
  logic [6:0]    rf_cnt;
  logic [2:0]    restored;

  cmrt_pkg::rsp_t out;
  logic          out_valid;

  assign req_stall = (state != cmrt_pkg::S_IDLE);
  assign rsp_valid = out_valid;
  assign rsp       = out;

  logic map_done, ref_done;
  assign map_done = (mi == cmrt_pkg::MAP_CNT_W'(cmrt_pkg::MAP_ENTRIES - 1));
  assign ref_done = (ri == cmrt_pkg::REF_CNT_W'(cmrt_pkg::FRAME_ENTRIES - 1));

  // compare against registered read
  logic pid_is_first, pid_is_child, page_eq;
  assign page_eq      = rd_valid && (rd_page == page);
  assign pid_is_first = page_eq && (rd_pid == r.first_pid);
  assign pid_is_child = page_eq && (rd_pid == r.child_pid);

  always_comb begin
    state_next = state;
    unique case (state)
      cmrt_pkg::S_IDLE:    if (req_valid) state_next = cmrt_pkg::S_MAP_RD;
      cmrt_pkg::S_MAP_RD:  state_next = cmrt_pkg::S_MAP_CHK;
      cmrt_pkg::S_MAP_CHK: state_next = map_done ? cmrt_pkg::S_DECIDE : cmrt_pkg::S_MAP_RD;
      cmrt_pkg::S_DECIDE:  state_next = cmrt_pkg::S_REF_RD;
      cmrt_pkg::S_REF_RD:  state_next = cmrt_pkg::S_REF_CHK;
      cmrt_pkg::S_REF_CHK: state_next = ref_done ? cmrt_pkg::S_APPLY : cmrt_pkg::S_REF_RD;
      cmrt_pkg::S_APPLY:   state_next = cmrt_pkg::S_OUT;
      cmrt_pkg::S_OUT:     if (!out_valid || !rsp_stall) state_next = cmrt_pkg::S_IDLE;
      default:             state_next = cmrt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= cmrt_pkg::S_IDLE;
    else     state <= state_next;
  end

  // registered table reads
  always_ff @(posedge clk) begin
    rd_pid    <= map_pid[mi[MW-1:0]];
    rd_page   <= map_vpn[mi[MW-1:0]];
    rd_rframe <= ref_frame[ri[RW-1:0]];
    rd_rcnt   <= ref_cnt[ri[RW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      rd_rvalid <= 1'b0;
    end else begin
      rd_valid  <= map_valid[mi[MW-1:0]];
      rd_rvalid <= ref_valid[ri[RW-1:0]];
    end
  end

  logic [2:0] in_perms;
  assign in_perms = {r.perm_exec, r.perm_user, r.perm_writable};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      map_valid <= '0;
      ref_valid <= '0;
    end else begin
      if (out_valid && !rsp_stall) out_valid <= 1'b0;
      unique case (state)
        cmrt_pkg::S_IDLE: if (req_valid) begin
          r     <= req;
          page  <= req.virtual_address[63:12];
          frame <= req.frame_address[51:12];
          mi    <= '0;
          ri    <= '0;
          pm_hit <= 1'b0; cm_hit <= 1'b0; s1_ok <= 1'b0; s2_ok <= 1'b0;
          rf_hit <= 1'b0; rf_free_ok <= 1'b0;
          pm_idx <= '0; s1_idx <= '0; s2_idx <= '0; rf_idx <= '0; rf_free <= '0;
          rf_cnt <= '0;
          out   <= '0;
        end
        cmrt_pkg::S_MAP_RD: ;
        cmrt_pkg::S_MAP_CHK: begin
          // lowest match / lowest two free slots
          if (pid_is_first && !pm_hit) begin
            pm_hit <= 1'b1;
            pm_idx <= mi[MW-1:0];
          end
          if (pid_is_child) cm_hit <= 1'b1;
          if (!rd_valid) begin
            if (!s1_ok) begin
              s1_ok <= 1'b1; s1_idx <= mi[MW-1:0];
            end else if (!s2_ok) begin
              s2_ok <= 1'b1; s2_idx <= mi[MW-1:0];
            end
          end
          mi <= mi + 1'b1;
        end
        cmrt_pkg::S_DECIDE: begin
          // fault uses the matching entry's frame for the count lookup
          if (r.req_type == cmrt_pkg::REQ_FAULT) begin
            frame    <= map_frame[pm_idx];
            restored <= map_perms[pm_idx];
          end else begin
            restored <= pm_hit ? map_perms[pm_idx] : in_perms;
          end
        end
        cmrt_pkg::S_REF_RD: ;
        cmrt_pkg::S_REF_CHK: begin
          if (rd_rvalid && rd_rframe == frame && !rf_hit) begin
            rf_hit <= 1'b1; rf_idx <= ri[RW-1:0]; rf_cnt <= rd_rcnt;
          end
          if (!rd_rvalid && !rf_free_ok) begin
            rf_free_ok <= 1'b1; rf_free <= ri[RW-1:0];
          end
          ri <= ri + 1'b1;
        end
        cmrt_pkg::S_APPLY: begin
          out_valid <= 1'b1;
          if (r.req_type == cmrt_pkg::REQ_SHARE) begin
            if (r.virtual_address[11:0] != 12'd0) begin
              out.status <= cmrt_pkg::ST_UNALIGNED;
            end else if (r.large_page) begin
              out.status <= cmrt_pkg::ST_LARGE;
            end else if (!restored[0]) begin
              out.status <= cmrt_pkg::ST_PLAIN;
              {out.map_exec, out.map_user, out.map_writable} <= restored;
            end else if (cm_hit) begin
              out.status <= cmrt_pkg::ST_DUP;
            end else if (!s1_ok || (!pm_hit && !s2_ok) || (!rf_hit && !rf_free_ok)) begin
              out.status <= cmrt_pkg::ST_FULL;
            end else begin
              out.status <= cmrt_pkg::ST_SHARED;
              {out.map_exec, out.map_user, out.map_writable} <= {restored[2:1], 1'b0};
              out.parent_make_readonly <= !pm_hit;
              map_valid[s1_idx] <= 1'b1;
              map_vpn[s1_idx]   <= page;
              map_frame[s1_idx] <= frame;
              map_perms[s1_idx] <= restored;
              map_pid[s1_idx]   <= pm_hit ? r.child_pid : r.first_pid;
              if (!pm_hit) begin
                map_valid[s2_idx] <= 1'b1;
                map_vpn[s2_idx]   <= page;
                map_frame[s2_idx] <= frame;
                map_perms[s2_idx] <= restored;
                map_pid[s2_idx]   <= r.child_pid;
              end
              // add one or two counts, saturating at COUNT_MAX
              if (rf_hit) begin
                if (pm_hit || rf_cnt >= cmrt_pkg::COUNT_MAX - 7'd1)
                  ref_cnt[rf_idx] <= (rf_cnt == cmrt_pkg::COUNT_MAX) ? rf_cnt :
                                     (pm_hit ? rf_cnt + 7'd1 : cmrt_pkg::COUNT_MAX);
                else
                  ref_cnt[rf_idx] <= rf_cnt + 7'd2;
              end else begin
                ref_valid[rf_free] <= 1'b1;
                ref_frame[rf_free] <= frame;
                ref_cnt[rf_free]   <= pm_hit ? 7'd1 : 7'd2;
              end
            end
          end else begin
            if (!r.trap_valid || r.fault_error_bits != 2'b11) begin
              out.status <= cmrt_pkg::ST_INVALID;
            end else if (!pm_hit) begin
              out.status <= cmrt_pkg::ST_NOT_COW;
            end else if (rf_hit && rf_cnt > 7'd1 && !r.alloc_ok) begin
              out.status <= cmrt_pkg::ST_NO_MEM;
            end else begin
              {out.map_exec, out.map_user, out.map_writable} <= restored;
              if (rf_hit && rf_cnt > 7'd1) begin
                out.status       <= cmrt_pkg::ST_COPIED;
                out.copy_frame   <= {frame, 12'd0};
                ref_cnt[rf_idx]  <= rf_cnt - 7'd1;
              end else begin
                out.status <= cmrt_pkg::ST_RESTORED;
                if (rf_hit) begin
                  ref_valid[rf_idx] <= 1'b0;
                  ref_cnt[rf_idx]   <= '0;
                end
              end
              map_valid[pm_idx] <= 1'b0;
            end
          end
        end
        cmrt_pkg::S_OUT: ;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/cmrt_checker.sv
// ---------------------------------------------------------------------------
// cmrt_checker: port-level checks
// Watches handshakes and result fields of the tracker from its ports.
// ---------------------------------------------------------------------------
module cmrt_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input cmrt_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input cmrt_pkg::rsp_t rsp
);

  // accepted word blocks further requests next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall) else $error("accept while busy");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp)) else $error("rsp dropped");

  a_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status <= cmrt_pkg::ST_NO_MEM) else $error("bad status");

  a_ro: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.parent_make_readonly |-> rsp.status == cmrt_pkg::ST_SHARED)
    else $error("readonly on wrong status");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !rsp_valid)
    else $error("rsp after reset");

endmodule

bind cow_mapping_refcount_table_core cmrt_checker u_cmrt_checker (.*);
